// ===== hdl/top_k_extreme_average_defines.svh =====
// Assertion macros shared by the checker of the top-k extreme average block.
// Each macro samples on aclk; the first two are quiet while aresetn is low.
`ifndef TOP_K_EXTREME_AVERAGE_DEFINES_SVH
`define TOP_K_EXTREME_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TKEA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TKEA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define TKEA_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/tkea_pkg.sv =====
`timescale 1ns / 1ps

package tkea_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int KC_W         = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int MAX_KEPT_DEF = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEPT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FILL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FILL = 3'd3;

    // register values after reset
    localparam logic                RST_SELECT    = 1'b0;
    localparam logic [KC_W-1:0]     RST_KEPT      = 5'd16;
    localparam logic [SAMPLE_W-1:0] RST_LOW_FILL  = 16'd0;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_FILL = 16'd64000;

    // control that the top level broadcasts to every cell
    typedef struct packed {
        logic load;     // refill with the fill value
        logic shift;    // move toward cell 0 while summing
        logic insert;   // an item is accepted this cycle
        logic smallest; // keep the smallest samples
    } cell_ctrl_t;

endpackage

// ===== hdl/top_k_extreme_average.sv =====
`timescale 1ns / 1ps

// Top-k extreme average. Samples (unsigned Q10.6) stream in on the s_ channel;
// a row of MAX_KEPT cells holds the K strongest so far, sorted weakest first,
// largest or smallest by REG_SELECT. Every cell compares itself with the
// incoming sample in the same cycle and shifts or captures it, so a sample
// that is not marked last needs no further work and the next item is taken
// right after it unless a configuration write holds s_ready low. On the item
// marked last the row drains into an accumulator, one cell a cycle, which
// also refills the row with the fill value; a restoring divider then takes
// one quotient bit a cycle. After the item marked last is taken, s_ready
// therefore stays low through the drain, the division and the hand-over,
// longer while an earlier average still waits on m_ready, and the new average
// appears on m_average in the cycle s_ready returns, held until taken. Any
// configuration write refills the row with the fill value of the mode that
// the write leaves selected, and s_ready is low in that cycle. A kept value
// of 0 acts as 1, any value above MAX_KEPT as MAX_KEPT.

module top_k_extreme_average
    import tkea_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_average
);

    localparam int KW    = $clog2(MAX_KEPT + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_KEPT);
    localparam int CMPW  = (KW > KC_W) ? KW : KC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // configuration registers
    logic                select_reg, select_next;
    logic [KC_W-1:0]     kept_reg,   kept_next;
    logic [SAMPLE_W-1:0] low_reg,    low_next;
    logic [SAMPLE_W-1:0] high_reg,   high_next;

    logic [1:0]          state_reg, state_next;
    logic [KW-1:0]       cnt_reg,   cnt_next;
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_average_reg, m_average_next;

    logic [KW-1:0]       eff_k;
    logic [CMPW-1:0]     kept_ext;
    logic [SAMPLE_W-1:0] fill;
    logic                accept;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quo;
    cell_ctrl_t          ctrl;

    logic [SAMPLE_W-1:0] cell_value [MAX_KEPT];
    logic [MAX_KEPT-1:0] cell_beat;
    logic [MAX_KEPT-1:0] cell_active;

    // register writes; the row refills from the values the write leaves behind
    always_comb begin
        select_next = select_reg;
        kept_next   = kept_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SELECT:    select_next = cfg_wdata[0];
                REG_KEPT:      kept_next   = cfg_wdata[KC_W-1:0];
                REG_LOW_FILL:  low_next    = cfg_wdata[SAMPLE_W-1:0];
                REG_HIGH_FILL: high_next   = cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_reg <= RST_SELECT;
            kept_reg   <= RST_KEPT;
            low_reg    <= RST_LOW_FILL;
            high_reg   <= RST_HIGH_FILL;
        end else begin
            select_reg <= select_next;
            kept_reg   <= kept_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
        end
    end

    // equals the current fill when no write is under way
    assign fill = select_next ? high_next : low_next;

    // clamp K into 1..MAX_KEPT
    assign kept_ext = CMPW'(kept_reg);
    always_comb begin
        if (kept_ext == '0) begin
            eff_k = KW'(1);
        end else if (kept_ext > CMPW'(MAX_KEPT)) begin
            eff_k = KW'(MAX_KEPT);
        end else begin
            eff_k = kept_ext[KW-1:0];
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign accept  = s_valid && s_ready;

    assign ctrl.load     = cfg_wr_en;
    assign ctrl.shift    = (state_reg == ST_SUM);
    assign ctrl.insert   = accept;
    assign ctrl.smallest = select_reg;

    // the row of cells; cell 0 holds the weakest kept entry
    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
        logic [SAMPLE_W-1:0] up_value;
        logic                up_beat;

        assign cell_active[i] = (KW'(i) < eff_k);

        if (i == MAX_KEPT - 1) begin : g_top
            // the strongest end draws in the fill value while draining
            assign up_value = fill;
            assign up_beat  = 1'b0;
        end else begin : g_mid
            assign up_value = cell_value[i+1];
            assign up_beat  = cell_beat[i+1];
        end

        tkea_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .active   (cell_active[i]),
            .sample   (s_sample),
            .fill     (fill),
            .up_value (up_value),
            .up_beat  (up_beat),
            .value    (cell_value[i]),
            .beat     (cell_beat[i])
        );
    end

    tkea_div #(
        .DW (SUM_W),
        .VW (KW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (eff_k),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer: drain and sum, divide, then hand over the result
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        div_start      = 1'b0;
        m_valid_next   = m_valid_reg;
        m_average_next = m_average_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_last) begin
                    state_next = ST_SUM;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_SUM: begin
                // add the entry leaving cell 0
                sum_next = sum_reg + SUM_W'(cell_value[0]);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == eff_k - 1'b1) begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_average_next = div_quo[SAMPLE_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg       <= sum_next;
        m_average_reg <= m_average_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

endmodule

// ===== hdl/tkea_cell.sv =====
`timescale 1ns / 1ps

module tkea_cell
    import tkea_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic                active,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] fill,
    input  logic [SAMPLE_W-1:0] up_value,
    input  logic                up_beat,
    output logic [SAMPLE_W-1:0] value,
    output logic                beat
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;

    // sample strictly beats this entry
    assign beat = active && (ctrl.smallest ? (value_reg > sample) : (value_reg < sample));

    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            value_next = fill;
        end else if (ctrl.shift) begin
            value_next = up_value;
        end else if (ctrl.insert && beat) begin
            // take the stronger neighbor if it is beaten too, else the sample
            value_next = up_beat ? up_value : sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= RST_LOW_FILL;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== hdl/tkea_div.sv =====
`timescale 1ns / 1ps

module tkea_div #(
    parameter int DW = 20,
    parameter int VW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int SW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [VW-1:0] rem_reg,  rem_next;
    logic [DW-1:0] quo_reg,  quo_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
            quo_next  = {quo_reg[DW-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/tkea_checker.sv =====
`timescale 1ns / 1ps

`include "top_k_extreme_average_defines.svh"

module tkea_checker
    import tkea_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [SAMPLE_W-1:0]   s_sample,
    input logic                  s_last,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [SAMPLE_W-1:0]   m_average
);

    // a pending result stays put until taken
    `TKEA_ASSERT_NXT(a_m_hold, m_valid && !m_ready, m_valid)
    `TKEA_ASSERT_NXT(a_m_stable, m_valid && !m_ready, $stable(m_average))

    // the item closing a set stalls input while the average is formed
    `TKEA_ASSERT_NXT(a_last_stalls, s_valid && s_ready && s_last, !s_ready)

    // no input is taken in a cycle that refills the row
    `TKEA_ASSERT_IMP(a_cfg_blocks, cfg_wr_en, !s_ready)

    // reset leaves no result behind
    `TKEA_ASSERT_RST(a_rst_clear, !aresetn, !m_valid)

endmodule

bind top_k_extreme_average tkea_checker u_tkea_checker (.*);
